/* hdl/u8d_pkg.sv */
// Shared types and constants for the UTF-8 sequence decoder.
// No dependencies; used by u8d_lane, u8d_merge and utf8_sequence_decoder.
package u8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 6;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned NUM_CONT = 3;

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

  localparam logic [CP_W-1:0] MAX_CP_RESET = 21'h10FFFF;

  localparam logic [POS_W-1:0] FAULT_NONE = 3'd0;
  localparam logic [POS_W-1:0] FAULT_POS1 = 3'd1;
  localparam logic [POS_W-1:0] FAULT_POS2 = 3'd2;
  localparam logic [POS_W-1:0] FAULT_POS3 = 3'd3;
  localparam logic [POS_W-1:0] FAULT_POS4 = 3'd4;

  localparam logic [POS_W-1:0] WIDTH_ERR = 3'd0;
  localparam logic [POS_W-1:0] WIDTH_1   = 3'd1;
  localparam logic [POS_W-1:0] WIDTH_2   = 3'd2;
  localparam logic [POS_W-1:0] WIDTH_3   = 3'd3;
  localparam logic [POS_W-1:0] WIDTH_4   = 3'd4;

  // What one lane reports about a continuation byte
  typedef struct packed {
    logic               zero;
    logic               cont;
    logic [GROUP_W-1:0] bits;
  } lane_info_t;

  typedef struct packed {
    logic [POS_W-1:0] seq_width;
    logic [POS_W-1:0] fault_position;
    logic [CP_W-1:0]  code_point;
  } decode_t;

endpackage

/* hdl/u8d_lane.sv */
// Per-byte lane: checks one continuation byte and extracts its 6-bit group.
// Depends on u8d_pkg.
module u8d_lane (
  input  logic [u8d_pkg::BYTE_W-1:0] byte_i,
  output u8d_pkg::lane_info_t        info_o
);

  always_comb begin
    info_o.zero = (byte_i == '0);
    info_o.cont = ((byte_i & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG);
    info_o.bits = byte_i[u8d_pkg::GROUP_W-1:0];
  end

endmodule

/* hdl/u8d_merge.sv */
// Merge stage: classifies the lead byte, combines lane flags into a fault
// position and assembles the code point. Depends on u8d_pkg.
module u8d_merge (
  input  logic [u8d_pkg::BYTE_W-1:0] lead_i,
  input  u8d_pkg::lane_info_t        lane_i [u8d_pkg::NUM_CONT],
  input  logic [u8d_pkg::CP_W-1:0]   max_cp_i,
  output u8d_pkg::decode_t           res_o
);

  logic                      lead2, lead3, lead4;
  logic [u8d_pkg::CP_W-1:0]  cp4, cp3, cp2, cp1;
  logic [u8d_pkg::POS_W-1:0] fault;
  logic [u8d_pkg::POS_W-1:0] width;
  logic [u8d_pkg::CP_W-1:0]  cp;

  assign lead4 = ((lead_i & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_TAG);
  assign lead3 = ((lead_i & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_TAG);
  assign lead2 = ((lead_i & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_TAG);

  assign cp4 = {lead_i[2:0], lane_i[0].bits, lane_i[1].bits, lane_i[2].bits};
  assign cp3 = {5'd0, lead_i[3:0], lane_i[0].bits, lane_i[1].bits};
  assign cp2 = {10'd0, lead_i[4:0], lane_i[0].bits};
  assign cp1 = {13'd0, lead_i};

  always_comb begin
    fault = u8d_pkg::FAULT_NONE;
    width = u8d_pkg::WIDTH_ERR;
    cp    = '0;
    priority if (lead4) begin
      priority if (lane_i[0].zero) fault = u8d_pkg::FAULT_POS1;
      else if (lane_i[1].zero || !lane_i[0].cont) fault = u8d_pkg::FAULT_POS2;
      else if (lane_i[2].zero || !lane_i[1].cont) fault = u8d_pkg::FAULT_POS3;
      else if (!lane_i[2].cont || (cp4 > max_cp_i)) fault = u8d_pkg::FAULT_POS4;
      else begin
        width = u8d_pkg::WIDTH_4;
        cp    = cp4;
      end
    end else if (lead3) begin
      priority if (lane_i[0].zero) fault = u8d_pkg::FAULT_POS1;
      else if (lane_i[1].zero || !lane_i[0].cont) fault = u8d_pkg::FAULT_POS2;
      else if (!lane_i[1].cont) fault = u8d_pkg::FAULT_POS3;
      else begin
        width = u8d_pkg::WIDTH_3;
        cp    = cp3;
      end
    end else if (lead2) begin
      priority if (lane_i[0].zero) fault = u8d_pkg::FAULT_POS1;
      else if (!lane_i[0].cont) fault = u8d_pkg::FAULT_POS2;
      else begin
        width = u8d_pkg::WIDTH_2;
        cp    = cp2;
      end
    end else if (lead_i[u8d_pkg::BYTE_W-1]) begin
      // stray continuation byte or 11111xxx lead
      fault = u8d_pkg::FAULT_POS1;
    end else begin
      width = u8d_pkg::WIDTH_1;
      cp    = cp1;
    end
  end

  assign res_o.seq_width      = width;
  assign res_o.fault_position = fault;
  assign res_o.code_point     = cp;

endmodule

/* hdl/utf8_sequence_decoder.sv */
// UTF-8 sequence decoder: two-stage pipeline, lanes then merge.
// Each window is registered first with its lane results, then as the merged result.
// Throughput: one window per cycle; each stage holds one transaction and
// advances when the stage after it is empty or being drained.
// Reset (rst_n, synchronous, active low) empties both stages and sets the
// maximum code point to 0x10FFFF. Depends on u8d_pkg, u8d_lane, u8d_merge.
module utf8_sequence_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_lead_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_third_byte,
  input  logic [7:0]  in_fourth_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_seq_width,
  output logic [2:0]  out_fault_position,
  output logic [20:0] out_code_point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_max_code_point
);

  logic [u8d_pkg::CP_W-1:0]   max_cp_r;
  logic [u8d_pkg::BYTE_W-1:0] cont_byte [u8d_pkg::NUM_CONT];
  u8d_pkg::lane_info_t        lane_nxt  [u8d_pkg::NUM_CONT];
  u8d_pkg::lane_info_t        lane_r    [u8d_pkg::NUM_CONT];
  logic [u8d_pkg::BYTE_W-1:0] lead_r;
  logic                       s1_valid_r;
  logic                       s1_ready;
  logic                       s2_ready;
  u8d_pkg::decode_t           res_nxt;
  u8d_pkg::decode_t           res_r;
  logic                       out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cp_r <= u8d_pkg::MAX_CP_RESET;
    end else if (cfg_valid) begin
      max_cp_r <= cfg_max_code_point;
    end
  end

  assign cont_byte[0] = in_second_byte;
  assign cont_byte[1] = in_third_byte;
  assign cont_byte[2] = in_fourth_byte;

  for (genvar i = 0; i < u8d_pkg::NUM_CONT; i++) begin : g_lane
    u8d_lane u_lane (
      .byte_i (cont_byte[i]),
      .info_o (lane_nxt[i])
    );
  end

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: lane results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      lead_r <= in_lead_byte;
      for (int i = 0; i < u8d_pkg::NUM_CONT; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
    end
  end

  u8d_merge u_merge (
    .lead_i   (lead_r),
    .lane_i   (lane_r),
    .max_cp_i (max_cp_r),
    .res_o    (res_nxt)
  );

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seq_width      = res_r.seq_width;
  assign out_fault_position = res_r.fault_position;
  assign out_code_point     = res_r.code_point;

endmodule

/* tb/sv/utf8_sequence_decoder_test.sv */
// Self-checking testbench for utf8_sequence_decoder: directed windows, then
// random windows over several maximum code point settings with random idling.
// Depends on u8d_pkg and the utf8_sequence_decoder RTL.
module utf8_sequence_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 285;

  typedef struct {
    logic [3:0][7:0]  win;
    bit               known;
    u8d_pkg::decode_t want;
  } window_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_lead_byte = '0;
  logic [7:0]  in_second_byte = '0;
  logic [7:0]  in_third_byte = '0;
  logic [7:0]  in_fourth_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_seq_width;
  logic [2:0]  out_fault_position;
  logic [20:0] out_code_point;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [20:0] cfg_max_code_point = '0;

  // Typed expectation travelling with the window currently on the bus
  bit               tag_known = 1'b0;
  u8d_pkg::decode_t tag_decode = '0;

  logic [u8d_pkg::CP_W-1:0] cp_limit = u8d_pkg::MAX_CP_RESET;
  u8d_pkg::decode_t         pending_decodes[$];
  window_row_t              directed_rows[$];
  int unsigned              mismatch_count = 0;
  int unsigned              cycle_count = 0;
  int unsigned              burst_left = 0;
  bit                       valid_up = 1'b0;
  bit                       steady = 1'b0;

  utf8_sequence_decoder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_lead_byte       (in_lead_byte),
    .in_second_byte     (in_second_byte),
    .in_third_byte      (in_third_byte),
    .in_fourth_byte     (in_fourth_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_seq_width      (out_seq_width),
    .out_fault_position (out_fault_position),
    .out_code_point     (out_code_point),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_code_point (cfg_max_code_point)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit cont_form(input logic [7:0] b);
    return (b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG;
  endfunction

  function automatic u8d_pkg::decode_t decode_window(
    input logic [3:0][7:0]          w,
    input logic [u8d_pkg::CP_W-1:0] limit);
    u8d_pkg::decode_t d;
    d = '0;
    if ((w[0] & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_TAG) begin
      if (w[1] == 8'h00) d.fault_position = u8d_pkg::FAULT_POS1;
      else if (w[2] == 8'h00 || !cont_form(w[1])) d.fault_position = u8d_pkg::FAULT_POS2;
      else if (w[3] == 8'h00 || !cont_form(w[2])) d.fault_position = u8d_pkg::FAULT_POS3;
      else if (!cont_form(w[3])) d.fault_position = u8d_pkg::FAULT_POS4;
      else begin
        d.code_point = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        if (d.code_point > limit) d.fault_position = u8d_pkg::FAULT_POS4;
        else d.seq_width = u8d_pkg::WIDTH_4;
      end
    end else if ((w[0] & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_TAG) begin
      if (w[1] == 8'h00) d.fault_position = u8d_pkg::FAULT_POS1;
      else if (w[2] == 8'h00 || !cont_form(w[1])) d.fault_position = u8d_pkg::FAULT_POS2;
      else if (!cont_form(w[2])) d.fault_position = u8d_pkg::FAULT_POS3;
      else begin
        d.code_point = {5'b0, w[0][3:0], w[1][5:0], w[2][5:0]};
        d.seq_width  = u8d_pkg::WIDTH_3;
      end
    end else if ((w[0] & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_TAG) begin
      if (w[1] == 8'h00) d.fault_position = u8d_pkg::FAULT_POS1;
      else if (!cont_form(w[1])) d.fault_position = u8d_pkg::FAULT_POS2;
      else begin
        d.code_point = {10'b0, w[0][4:0], w[1][5:0]};
        d.seq_width  = u8d_pkg::WIDTH_2;
      end
    end else if ((w[0] & u8d_pkg::CONT_TAG) != 8'h00) begin
      d.fault_position = u8d_pkg::FAULT_POS1;
    end else begin
      d.code_point = {13'b0, w[0]};
      d.seq_width  = u8d_pkg::WIDTH_1;
    end
    if (d.fault_position != u8d_pkg::FAULT_NONE) begin
      d.seq_width  = u8d_pkg::WIDTH_ERR;
      d.code_point = '0;
    end
    return d;
  endfunction

  // Mostly well-formed sequences, some with one byte broken, the rest noise
  function automatic logic [3:0][7:0] random_window(input logic [u8d_pkg::CP_W-1:0] limit);
    logic [3:0][7:0]          w;
    logic [31:0]              r;
    logic [u8d_pkg::CP_W-1:0] cp;
    logic [1:0]               top;
    int                       kind;
    int                       span;
    int                       pos;
    int                       t;
    w = $urandom;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      span = $urandom_range(1, 4);
      r = $urandom;
      unique case (span)
        1: w[0] = {1'b0, r[6:0]};
        2: begin
          w[0] = {3'b110, r[4:0]};
          w[1] = {2'b10, r[10:5]};
        end
        3: begin
          w[0] = {4'b1110, r[3:0]};
          w[1] = {2'b10, r[9:4]};
          w[2] = {2'b10, r[15:10]};
        end
        default: begin
          cp = r[20:0];
          // land right around the configured maximum now and then
          if ($urandom_range(0, 3) == 0) begin
            t = int'(limit) - 2 + int'($urandom_range(0, 4));
            if (t < 0) t = 0;
            else if (t > 32'h1FFFFF) t = 32'h1FFFFF;
            cp = t[20:0];
          end
          w[0] = {5'b11110, cp[20:18]};
          w[1] = {2'b10, cp[17:12]};
          w[2] = {2'b10, cp[11:6]};
          w[3] = {2'b10, cp[5:0]};
        end
      endcase
      if (kind >= 60) begin
        pos = $urandom_range(0, span - 1);
        r = $urandom;
        if (pos == 0) begin
          w[0] = r[0] ? {2'b10, r[6:1]} : {5'b11111, r[3:1]};
        end else if (r[0]) begin
          w[pos] = 8'h00;
        end else begin
          top = r[2:1];
          if (top == 2'b10) top = 2'b11;
          w[pos] = {top, r[8:3]};
        end
      end
    end
    return w;
  endfunction

  task automatic add_row(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                         input logic [7:0] b3, input bit known, input logic [2:0] width,
                         input logic [2:0] fault, input logic [u8d_pkg::CP_W-1:0] cp);
    window_row_t row;
    row.win   = {b3, b2, b1, b0};
    row.known = known;
    row.want  = '{seq_width: width, fault_position: fault, code_point: cp};
    directed_rows.push_back(row);
  endtask

  task automatic report(input string field, input int want, input int got);
    mismatch_count++;
    $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  task automatic transmit(input logic [3:0][7:0] win, input bit known,
                          input u8d_pkg::decode_t want);
    int unsigned gap;
    in_valid       <= 1'b1;
    valid_up        = 1'b1;
    in_lead_byte   <= win[0];
    in_second_byte <= win[1];
    in_third_byte  <= win[2];
    in_fourth_byte <= win[3];
    tag_known      <= known;
    tag_decode     <= want;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      valid_up  = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = steady ? 400 : $urandom_range(0, 15);
    end
  endtask

  // Drop valid and hold off until every decode has come back
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up  = 1'b0;
    end
    do @(posedge clk); while (pending_decodes.size() != 0);
  endtask

  task automatic write_limit(input logic [u8d_pkg::CP_W-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_max_code_point <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    u8d_pkg::decode_t want;
    cycle_count++;
    unique case ((cycle_count / 128) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_count % 4) == 0;
      default: out_ready <= $urandom_range(0, 7) != 0;
    endcase
    if (!rst_n) begin
      cp_limit = u8d_pkg::MAX_CP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) cp_limit = cfg_max_code_point;
      if (in_valid && in_ready)
        pending_decodes.push_back(tag_known ? tag_decode :
          decode_window({in_fourth_byte, in_third_byte, in_second_byte, in_lead_byte},
                        cp_limit));
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with nothing expected, width %0d fault %0d cp %0h",
                   $time, out_seq_width, out_fault_position, out_code_point);
        end else begin
          want = pending_decodes.pop_front();
          if (out_seq_width != want.seq_width)
            report("seq_width", int'(want.seq_width), int'(out_seq_width));
          if (out_fault_position != want.fault_position)
            report("fault_position", int'(want.fault_position), int'(out_fault_position));
          if (out_code_point != want.code_point)
            report("code_point", int'(want.code_point), int'(out_code_point));
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [u8d_pkg::CP_W-1:0] limits[5];
    logic [31:0]              rnd;
    rnd = $urandom_range(0, 32'h1FFFFF);
    limits[0] = 21'h1FFFFF;
    limits[1] = 21'h000000;
    limits[2] = 21'h010000;
    limits[3] = rnd[u8d_pkg::CP_W-1:0];
    limits[4] = u8d_pkg::MAX_CP_RESET;

    // lead, second, third, fourth, typed?, width, fault, code point
    add_row(8'h00, 8'h00, 8'h00, 8'h00, 1, u8d_pkg::WIDTH_1,   u8d_pkg::FAULT_NONE, 21'h0);
    add_row(8'h7F, 8'hFF, 8'hFF, 8'hFF, 1, u8d_pkg::WIDTH_1,   u8d_pkg::FAULT_NONE, 21'h7F);
    add_row(8'h80, 8'h80, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS1, 21'h0);
    add_row(8'hBF, 8'h80, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS1, 21'h0);
    add_row(8'hF8, 8'h80, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS1, 21'h0);
    add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS1, 21'h0);
    add_row(8'hC2, 8'h00, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS1, 21'h0);
    add_row(8'hC2, 8'h41, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS2, 21'h0);
    add_row(8'hC2, 8'h80, 8'h00, 8'h00, 1, u8d_pkg::WIDTH_2,   u8d_pkg::FAULT_NONE, 21'h80);
    add_row(8'hDF, 8'hBF, 8'hFF, 8'hFF, 1, u8d_pkg::WIDTH_2,   u8d_pkg::FAULT_NONE, 21'h7FF);
    add_row(8'hC0, 8'h80, 8'h00, 8'h00, 1, u8d_pkg::WIDTH_2,   u8d_pkg::FAULT_NONE, 21'h0);
    add_row(8'hE0, 8'h80, 8'h00, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS2, 21'h0);
    add_row(8'hE0, 8'h41, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS2, 21'h0);
    add_row(8'hE0, 8'h80, 8'hC0, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS3, 21'h0);
    add_row(8'hEF, 8'hBF, 8'hBF, 8'h00, 1, u8d_pkg::WIDTH_3,   u8d_pkg::FAULT_NONE, 21'hFFFF);
    add_row(8'hED, 8'hA0, 8'h80, 8'h00, 0, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_NONE, 21'h0);
    add_row(8'hE2, 8'h82, 8'hAC, 8'h41, 0, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_NONE, 21'h0);
    add_row(8'hF0, 8'h00, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS1, 21'h0);
    add_row(8'hF0, 8'h80, 8'h80, 8'h00, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS3, 21'h0);
    add_row(8'hF0, 8'h7F, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS2, 21'h0);
    add_row(8'hF0, 8'h80, 8'hFF, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS3, 21'h0);
    add_row(8'hF0, 8'h80, 8'h80, 8'hC0, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS4, 21'h0);
    add_row(8'hF4, 8'h8F, 8'hBF, 8'hBF, 1, u8d_pkg::WIDTH_4,   u8d_pkg::FAULT_NONE, 21'h10FFFF);
    add_row(8'hF4, 8'h90, 8'h80, 8'h80, 1, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_POS4, 21'h0);
    add_row(8'hF0, 8'h9F, 8'h98, 8'h80, 0, u8d_pkg::WIDTH_ERR, u8d_pkg::FAULT_NONE, 21'h0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      transmit(directed_rows[i].win, directed_rows[i].known, directed_rows[i].want);

    foreach (limits[p]) begin
      settle();
      write_limit(limits[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // every so often run a stretch with no sender gaps
        if (n % 95 == 0) steady = $urandom_range(0, 3) == 0;
        transmit(random_window(limits[p]), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_decodes.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
